FILE: rtl/core/srig_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srig_pkg
// Types and constants shared by the sleep request idle gate.
// ----------------------------------------------------------------------------
package srig_pkg;

  localparam int unsigned HANDLE_W        = 6;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned DELAY_W         = 16;
  localparam int unsigned NUM_HANDLES_DEF = 32;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RESET = 16'd100;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APP_SET   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APP_CLR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DRV_SET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DRV_CLR   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic                store_busy;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic main_loop_run;
    logic stay_in_loop;
    logic sleep_notify;
    logic no_return;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/srig_holdoff.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srig_holdoff
// Hold-off counter: counts down per tick, saturating at zero, and is
// reloaded with min_delay at the end of a tick while requests persist.
// ----------------------------------------------------------------------------
module srig_holdoff (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         tick,
  input  wire logic                         reload,
  input  wire logic [srig_pkg::DELAY_W-1:0] min_delay,
  output logic                              cnt_zero
);

  logic [srig_pkg::DELAY_W-1:0] cnt_r;
  logic [srig_pkg::DELAY_W-1:0] cnt_nxt;
  logic [srig_pkg::DELAY_W-1:0] cnt_dec;

  // decremented value drives this tick's decisions
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
  assign cnt_zero = (cnt_dec == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (tick) begin
      cnt_nxt = reload ? min_delay : cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= srig_pkg::MIN_DELAY_RESET;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sleep_request_idle_gate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Output: a result is registered and valid in the cycle after its item's transfer.
// Throughput: one item per cycle; the input is held off only while a
// result waits in the output register and out_ready is low.
// Reset (synchronous, rst_n low): masks cleared, hold-off counters and
// min_delay at 100, main loop running, sleep armed, no point of no return.
// ----------------------------------------------------------------------------
// sleep_request_idle_gate_unit
// Keep-awake request masks, hold-off counters and one-time sleep decision.
// ----------------------------------------------------------------------------
module sleep_request_idle_gate_unit #(
  parameter int unsigned NUM_HANDLES = srig_pkg::NUM_HANDLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire srig_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output srig_pkg::out_item_t               out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [srig_pkg::DELAY_W-1:0] cfg_wr_data
);

  logic [srig_pkg::DELAY_W-1:0] min_delay_r;
  logic [NUM_HANDLES-1:0]       app_mask_r, app_mask_nxt;
  logic [NUM_HANDLES-1:0]       drv_mask_r, drv_mask_nxt;
  logic                         run_r, run_nxt;
  logic                         armed_r, armed_nxt;
  logic                         no_ret_r, no_ret_nxt;
  logic                         stay_r, stay_nxt;
  logic                         out_valid_r;
  srig_pkg::out_item_t          out_r, out_nxt;

  logic                         in_fire;
  logic                         tick;
  logic                         app_req, drv_req;
  logic                         app_zero, drv_zero;
  logic                         sleep_fire;
  logic                         in_range;
  logic [NUM_HANDLES-1:0]       hit_vec;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one-hot handle decode; out-of-range handles hit nothing
  always_comb begin
    for (int i = 0; i < NUM_HANDLES; i++) begin
      hit_vec[i] = (in_data.handle == srig_pkg::HANDLE_W'(i));
    end
  end
  assign in_range = |hit_vec;

  assign tick    = in_fire && (in_data.kind == srig_pkg::KIND_TICK);
  assign app_req = |app_mask_r;
  assign drv_req = |drv_mask_r;

  srig_holdoff u_app_holdoff (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .reload    (app_req),
    .min_delay (min_delay_r),
    .cnt_zero  (app_zero)
  );

  srig_holdoff u_drv_holdoff (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .reload    (drv_req),
    .min_delay (min_delay_r),
    .cnt_zero  (drv_zero)
  );

  assign sleep_fire = tick && !app_req && app_zero && !in_data.store_busy && armed_r;

  always_comb begin
    app_mask_nxt = app_mask_r;
    drv_mask_nxt = drv_mask_r;
    run_nxt      = run_r;
    armed_nxt    = armed_r;
    no_ret_nxt   = no_ret_r;
    stay_nxt     = stay_r;
    out_nxt      = '0;

    if (in_fire) begin
      unique case (in_data.kind)
        srig_pkg::KIND_TICK: begin
          if (app_req || drv_req) begin
            run_nxt = 1'b1;
          end else if (app_zero && drv_zero) begin
            run_nxt = 1'b0;
          end
          if (app_req) begin
            armed_nxt = 1'b1;
          end else if (sleep_fire) begin
            armed_nxt  = 1'b0;
            no_ret_nxt = 1'b1;
            stay_nxt   = 1'b0;
          end
        end
        srig_pkg::KIND_APP_SET: begin
          if (!no_ret_r && in_range) begin
            app_mask_nxt     = app_mask_r | hit_vec;
            out_nxt.accepted = 1'b1;
          end
        end
        srig_pkg::KIND_APP_CLR: begin
          app_mask_nxt = app_mask_r & ~hit_vec;
        end
        srig_pkg::KIND_DRV_SET: begin
          drv_mask_nxt     = drv_mask_r | hit_vec;
          out_nxt.accepted = in_range;
        end
        srig_pkg::KIND_DRV_CLR: begin
          drv_mask_nxt = drv_mask_r & ~hit_vec;
        end
        default: begin
        end
      endcase
    end

    out_nxt.main_loop_run = run_nxt;
    out_nxt.stay_in_loop  = stay_nxt;
    out_nxt.sleep_notify  = sleep_fire;
    out_nxt.no_return     = no_ret_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= srig_pkg::MIN_DELAY_RESET;
      app_mask_r  <= '0;
      drv_mask_r  <= '0;
      run_r       <= 1'b1;
      armed_r     <= 1'b1;
      no_ret_r    <= 1'b0;
      stay_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_delay_r <= cfg_wr_data;
      end
      app_mask_r <= app_mask_nxt;
      drv_mask_r <= drv_mask_nxt;
      run_r      <= run_nxt;
      armed_r    <= armed_nxt;
      no_ret_r   <= no_ret_nxt;
      stay_r     <= stay_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // point of no return is sticky
  a_no_return_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    no_ret_r |=> no_ret_r)
    else $error("point of no return was cleared");

  // stay flag drops exactly when the point of no return is latched
  a_stay_matches: assert property (@(posedge clk) disable iff (!rst_n)
    stay_r != no_ret_r)
    else $error("stay flag and no-return flag disagree");

  // a sleep notification carries the latched sleep decision
  a_notify_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.sleep_notify) |-> (out_r.no_return && !out_r.stay_in_loop))
    else $error("sleep notify without sleep decision");

  // app set past the point of no return is refused
  a_app_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.kind == srig_pkg::KIND_APP_SET && no_ret_r) |=> !out_r.accepted)
    else $error("app set accepted after point of no return");

endmodule
`default_nettype wire

FILE: tb/sv/sleep_request_idle_gate_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleep_request_idle_gate_unit_tb
// Self-checking bench for the sleep request idle gate. A queue-fed driver
// offers requests and ticks in random bursts, and a monitor predicts every
// result from its own copy of the masks, hold-off counters and flags. Each
// result is checked field by field while the receiver stalls on its own
// pattern. min_delay is reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module sleep_request_idle_gate_unit_tb;
  import srig_pkg::*;

  localparam int unsigned NUM_HANDLES    = NUM_HANDLES_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          ITEMS_PER_PHASE = 265;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_item_t            in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [DELAY_W-1:0]  cfg_wr_data = '0;

  sleep_request_idle_gate_unit #(
    .NUM_HANDLES(NUM_HANDLES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // pending requests and expected gate status
  in_item_t  req_q[$];
  out_item_t status_q[$];
  out_item_t status_want;

  int pushed_cnt  = 0;
  int sent_cnt    = 0;
  int err_cnt     = 0;
  int idle_cycles = 0;

  // gate model
  logic [63:0]        app_keep;
  logic [63:0]        drv_keep;
  logic [DELAY_W-1:0] app_hold;
  logic [DELAY_W-1:0] drv_hold;
  logic [DELAY_W-1:0] reload_ticks;
  logic               loop_on;
  logic               sleep_armed;
  logic               beyond_return;
  logic               keep_looping;

  // sender burst state
  int burst_left = 0;
  int gap_left   = 0;

  // receiver state
  rx_mode_t rx_mode   = RX_ALWAYS;
  int       mode_left = 0;
  int       hold_left = 0;
  int       out_seen  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t gate_predict(in_item_t req);
    out_item_t   res;
    logic        in_range;
    logic        app_live;
    logic        drv_live;
    logic [63:0] sel;
    res      = '0;
    in_range = (req.handle < NUM_HANDLES);
    sel      = 64'd1 << req.handle;
    case (req.kind)
      KIND_TICK: begin
        if (app_hold != '0) app_hold = app_hold - 1'b1;
        if (drv_hold != '0) drv_hold = drv_hold - 1'b1;
        app_live = (app_keep != '0);
        drv_live = (drv_keep != '0);
        if (app_live || drv_live) begin
          loop_on = 1'b1;
        end else if (app_hold == '0 && drv_hold == '0) begin
          loop_on = 1'b0;
        end
        if (app_live) begin
          app_hold    = reload_ticks;
          sleep_armed = 1'b1;
        end else if (app_hold == '0 && !req.store_busy && sleep_armed) begin
          sleep_armed      = 1'b0;
          beyond_return    = 1'b1;
          keep_looping     = 1'b0;
          res.sleep_notify = 1'b1;
        end
        if (drv_live) drv_hold = reload_ticks;
      end
      KIND_APP_SET: begin
        if (in_range && !beyond_return) begin
          app_keep     = app_keep | sel;
          res.accepted = 1'b1;
        end
      end
      KIND_APP_CLR: begin
        if (in_range) app_keep = app_keep & ~sel;
      end
      KIND_DRV_SET: begin
        if (in_range) begin
          drv_keep     = drv_keep | sel;
          res.accepted = 1'b1;
        end
      end
      KIND_DRV_CLR: begin
        if (in_range) drv_keep = drv_keep & ~sel;
      end
      default: ;
    endcase
    res.main_loop_run = loop_on;
    res.stay_in_loop  = keep_looping;
    res.no_return     = beyond_return;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  function automatic in_item_t mk_req(logic [KIND_W-1:0] k, logic [HANDLE_W-1:0] h,
                                      logic busy);
    in_item_t r;
    r.kind       = k;
    r.handle     = h;
    r.store_busy = busy;
    return r;
  endfunction

  // bias toward a few handles so that clears hit earlier sets
  function automatic logic [HANDLE_W-1:0] rand_handle();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 5) return HANDLE_W'($urandom_range(7, 0));
    if (pick < 8) return HANDLE_W'($urandom_range(NUM_HANDLES - 1, 0));
    return HANDLE_W'($urandom_range(63, NUM_HANDLES));
  endfunction

  function automatic in_item_t rand_request();
    int               pick;
    logic [KIND_W-1:0] k;
    pick = $urandom_range(99, 0);
    if (pick < 40)      k = KIND_TICK;
    else if (pick < 55) k = KIND_APP_SET;
    else if (pick < 68) k = KIND_APP_CLR;
    else if (pick < 80) k = KIND_DRV_SET;
    else if (pick < 92) k = KIND_DRV_CLR;
    else                k = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
    return mk_req(k, rand_handle(), ($urandom_range(2, 0) == 0));
  endfunction

  task automatic queue_req(input in_item_t r);
    req_q.push_back(r);
    pushed_cnt++;
  endtask

  // keep-awake session: set, a few ticks, clear, then ticks toward expiry
  task automatic push_session(input logic [DELAY_W-1:0] dly);
    logic [HANDLE_W-1:0] h_app;
    logic [HANDLE_W-1:0] h_drv;
    int                  tail;
    h_app = rand_handle();
    h_drv = rand_handle();
    queue_req(mk_req(KIND_APP_SET, h_app, ($urandom_range(1, 0) == 1)));
    if ($urandom_range(1, 0))
      queue_req(mk_req(KIND_DRV_SET, h_drv, ($urandom_range(1, 0) == 1)));
    repeat ($urandom_range(4, 1))
      queue_req(mk_req(KIND_TICK, rand_handle(), ($urandom_range(3, 0) == 0)));
    queue_req(mk_req(KIND_APP_CLR, h_app, ($urandom_range(1, 0) == 1)));
    queue_req(mk_req(KIND_DRV_CLR, h_drv, ($urandom_range(1, 0) == 1)));
    tail = ((dly > 6) ? 6 : int'(dly)) + 2;
    repeat (tail) queue_req(mk_req(KIND_TICK, rand_handle(), ($urandom_range(3, 0) == 0)));
  endtask

  task automatic wait_drained();
    while (sent_cnt != pushed_cnt || status_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_min_delay(input logic [DELAY_W-1:0] dly);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dly;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [DELAY_W-1:0] dly, input int n);
    int target;
    program_min_delay(dly);
    target = pushed_cnt + n;
    while (pushed_cnt < target) begin
      if ($urandom_range(9, 0) < 7) push_session(dly);
      else queue_req(rand_request());
    end
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= req_q.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(24, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus two long hold-offs mid-run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_seen++;
        if (out_seen == 400 || out_seen == 1000) hold_left = 250;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(3, 0));
        mode_left = $urandom_range(80, 10);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(1, 0) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // monitor: check results first, then predict the new transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      app_keep      = '0;
      drv_keep      = '0;
      app_hold      = MIN_DELAY_RESET;
      drv_hold      = MIN_DELAY_RESET;
      reload_ticks  = MIN_DELAY_RESET;
      loop_on       = 1'b1;
      sleep_armed   = 1'b1;
      beyond_return = 1'b0;
      keep_looping  = 1'b1;
      idle_cycles   = 0;
    end else begin
      if (cfg_wr_en) reload_ticks = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          flag_error($sformatf("unexpected result %b", out_data));
        end else begin
          status_want = status_q.pop_front();
          if (out_data.accepted      !== status_want.accepted      ||
              out_data.main_loop_run !== status_want.main_loop_run ||
              out_data.stay_in_loop  !== status_want.stay_in_loop  ||
              out_data.sleep_notify  !== status_want.sleep_notify  ||
              out_data.no_return     !== status_want.no_return) begin
            flag_error($sformatf(
              "status mismatch exp acc=%b run=%b stay=%b notify=%b nret=%b, got %b %b %b %b %b",
              status_want.accepted, status_want.main_loop_run, status_want.stay_in_loop,
              status_want.sleep_notify, status_want.no_return,
              out_data.accepted, out_data.main_loop_run, out_data.stay_in_loop,
              out_data.sleep_notify, out_data.no_return));
          end
        end
      end
      if (in_valid && in_ready) begin
        status_q.push_back(gate_predict(in_data));
        sent_cnt++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: handle extremes, out-of-range handles, unused kinds
    queue_req(mk_req(KIND_APP_SET, 6'd0, 1'b0));
    queue_req(mk_req(KIND_APP_SET, 6'd31, 1'b1));
    queue_req(mk_req(KIND_APP_SET, 6'd32, 1'b0));
    queue_req(mk_req(KIND_APP_SET, 6'd63, 1'b1));
    queue_req(mk_req(KIND_DRV_SET, 6'd63, 1'b0));
    queue_req(mk_req(KIND_DRV_SET, 6'd0, 1'b1));
    queue_req(mk_req(KIND_TICK, 6'd63, 1'b1));
    queue_req(mk_req(KIND_APP_CLR, 6'd0, 1'b0));
    queue_req(mk_req(KIND_APP_CLR, 6'd63, 1'b1));
    queue_req(mk_req(KIND_TICK, 6'd0, 1'b0));
    queue_req(mk_req(KIND_APP_CLR, 6'd31, 1'b0));
    queue_req(mk_req(KIND_DRV_CLR, 6'd63, 1'b1));
    queue_req(mk_req(KIND_DRV_CLR, 6'd0, 1'b0));
    queue_req(mk_req(KIND_UNUSED_FIRST, 6'd63, 1'b1));
    queue_req(mk_req(KIND_UNUSED_MID, 6'd0, 1'b0));
    queue_req(mk_req(KIND_UNUSED_LAST, 6'd42, 1'b1));
    queue_req(mk_req(KIND_TICK, 6'd21, 1'b0));
    queue_req(mk_req(KIND_DRV_SET, 6'd31, 1'b0));
    queue_req(mk_req(KIND_TICK, 6'd0, 1'b1));
    queue_req(mk_req(KIND_DRV_CLR, 6'd31, 1'b1));
    queue_req(mk_req(KIND_APP_SET, 6'd5, 1'b0));
    queue_req(mk_req(KIND_TICK, 6'd5, 1'b0));

    // long reload keeps the gate ahead of the point of no return first
    run_phase(16'hFFFF, ITEMS_PER_PHASE);
    run_phase(16'd1, ITEMS_PER_PHASE);
    run_phase(16'd0, ITEMS_PER_PHASE);
    run_phase(DELAY_W'($urandom_range(40, 2)), ITEMS_PER_PHASE);
    run_phase(DELAY_W'($urandom_range(8, 2)), ITEMS_PER_PHASE);

    wait_drained();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
